// ----- sv/vcd_pkg.sv -----
package vcd_pkg;

	localparam int POS_DEPTH   = 1024;
	localparam int TEX_DEPTH   = 1024;
	localparam int NRM_DEPTH   = 1024;
	localparam int DEDUP_DEPTH = 1024;

	localparam int POS_AW   = $clog2(POS_DEPTH);
	localparam int TEX_AW   = $clog2(TEX_DEPTH);
	localparam int NRM_AW   = $clog2(NRM_DEPTH);
	localparam int DEDUP_AW = $clog2(DEDUP_DEPTH);

	localparam int POS_CW   = $clog2(POS_DEPTH + 1);
	localparam int TEX_CW   = $clog2(TEX_DEPTH + 1);
	localparam int NRM_CW   = $clog2(NRM_DEPTH + 1);
	localparam int DEDUP_CW = $clog2(DEDUP_DEPTH + 1);

	localparam int IDX_W  = 11;
	localparam int WORD_W = 32;
	localparam int OUT_W  = 10;
	localparam int KEY_W  = 3 * IDX_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] FUNC_POS    = 2'd0;
	localparam logic [1:0] FUNC_TEX    = 2'd1;
	localparam logic [1:0] FUNC_NRM    = 2'd2;
	localparam logic [1:0] FUNC_CORNER = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [WORD_W-1:0] word_x;
		logic [WORD_W-1:0] word_y;
		logic [WORD_W-1:0] word_z;
		logic [IDX_W-1:0]  pos_index;
		logic [IDX_W-1:0]  tex_index;
		logic [IDX_W-1:0]  nrm_index;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0]  out_index;
		logic              is_new;
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] tex_u;
		logic [WORD_W-1:0] tex_v;
		logic [WORD_W-1:0] nrm_x;
		logic [WORD_W-1:0] nrm_y;
		logic [WORD_W-1:0] nrm_z;
		logic [1:0]        status;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] tex;
		logic [IDX_W-1:0] nrm;
		logic             bad;
	} corner_t;

	typedef struct packed {
		logic              we_pos;
		logic              we_tex;
		logic              we_nrm;
		logic [POS_AW-1:0] pos_addr;
		logic [TEX_AW-1:0] tex_addr;
		logic [NRM_AW-1:0] nrm_addr;
		logic [WORD_W-1:0] word_x;
		logic [WORD_W-1:0] word_y;
		logic [WORD_W-1:0] word_z;
	} attr_wr_t;

	typedef struct packed {
		logic              en;
		logic [POS_AW-1:0] pos_addr;
		logic [TEX_AW-1:0] tex_addr;
		logic [NRM_AW-1:0] nrm_addr;
	} attr_rd_t;

	typedef struct packed {
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] tex_u;
		logic [WORD_W-1:0] tex_v;
		logic [WORD_W-1:0] nrm_x;
		logic [WORD_W-1:0] nrm_y;
		logic [WORD_W-1:0] nrm_z;
	} attr_data_t;

	typedef struct packed {
		logic valid;
		logic [KEY_W-1:0] key;
		logic [DEDUP_AW-1:0] vidx;
	} slot_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_ATTR
	} back_state_t;

endpackage

// ----- sv/vcd_front.sv -----
module vcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  vcd_pkg::item_t      item,
	output logic                push,
	output vcd_pkg::corner_t    corner,
	output vcd_pkg::attr_wr_t   attr_wr
);

	logic [vcd_pkg::POS_CW-1:0] pos_cnt_q;
	logic [vcd_pkg::TEX_CW-1:0] tex_cnt_q;
	logic [vcd_pkg::NRM_CW-1:0] nrm_cnt_q;
	logic pos_room, tex_room, nrm_room;
	logic pos_ok, tex_ok, nrm_ok;

	// room left in each store
	assign pos_room = 32'(pos_cnt_q) < vcd_pkg::POS_DEPTH;
	assign tex_room = 32'(tex_cnt_q) < vcd_pkg::TEX_DEPTH;
	assign nrm_room = 32'(nrm_cnt_q) < vcd_pkg::NRM_DEPTH;

	// check one-based indexes against the loaded counts
	assign pos_ok = (item.pos_index != '0) && (32'(item.pos_index) <= 32'(pos_cnt_q));
	assign tex_ok = (item.tex_index != '0) && (32'(item.tex_index) <= 32'(tex_cnt_q));
	assign nrm_ok = (item.nrm_index != '0) && (32'(item.nrm_index) <= 32'(nrm_cnt_q));

	// classify the item: loads write a store, corners go to the queue
	always_comb begin
		attr_wr.we_pos   = accept && (item.func == vcd_pkg::FUNC_POS) && pos_room;
		attr_wr.we_tex   = accept && (item.func == vcd_pkg::FUNC_TEX) && tex_room;
		attr_wr.we_nrm   = accept && (item.func == vcd_pkg::FUNC_NRM) && nrm_room;
		attr_wr.pos_addr = pos_cnt_q[vcd_pkg::POS_AW-1:0];
		attr_wr.tex_addr = tex_cnt_q[vcd_pkg::TEX_AW-1:0];
		attr_wr.nrm_addr = nrm_cnt_q[vcd_pkg::NRM_AW-1:0];
		attr_wr.word_x   = item.word_x;
		attr_wr.word_y   = item.word_y;
		attr_wr.word_z   = item.word_z;
		push             = accept && (item.func == vcd_pkg::FUNC_CORNER);
		corner.pos       = item.pos_index;
		corner.tex       = item.tex_index;
		corner.nrm       = item.nrm_index;
		corner.bad       = !(pos_ok && tex_ok && nrm_ok);
	end

	// advance the fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_cnt_q <= '0;
			tex_cnt_q <= '0;
			nrm_cnt_q <= '0;
		end else begin
			if (attr_wr.we_pos) pos_cnt_q <= pos_cnt_q + 1'b1;
			if (attr_wr.we_tex) tex_cnt_q <= tex_cnt_q + 1'b1;
			if (attr_wr.we_nrm) nrm_cnt_q <= nrm_cnt_q + 1'b1;
		end
	end

endmodule

// ----- sv/vcd_fifo.sv -----
module vcd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vcd_pkg::corner_t wdata,
	input  logic             pop,
	output vcd_pkg::corner_t rdata,
	output logic             full,
	output logic             empty
);

	vcd_pkg::corner_t mem_q [vcd_pkg::FIFO_DEPTH];
	logic [vcd_pkg::FIFO_AW:0] wptr_q, rptr_q;

	assign empty = (wptr_q == rptr_q);
	assign full  = (wptr_q[vcd_pkg::FIFO_AW-1:0] == rptr_q[vcd_pkg::FIFO_AW-1:0]) &&
	               (wptr_q[vcd_pkg::FIFO_AW] != rptr_q[vcd_pkg::FIFO_AW]);
	assign rdata = mem_q[rptr_q[vcd_pkg::FIFO_AW-1:0]];

	// hold queued corners
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q[vcd_pkg::FIFO_AW-1:0]] <= wdata;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
		end
	end

endmodule

// ----- sv/vcd_attr.sv -----
module vcd_attr (
	input  logic                 clk,
	input  vcd_pkg::attr_wr_t    wr,
	input  vcd_pkg::attr_rd_t    rd,
	output vcd_pkg::attr_data_t  data
);

	logic [3*vcd_pkg::WORD_W-1:0] pos_mem [vcd_pkg::POS_DEPTH];
	logic [2*vcd_pkg::WORD_W-1:0] tex_mem [vcd_pkg::TEX_DEPTH];
	logic [3*vcd_pkg::WORD_W-1:0] nrm_mem [vcd_pkg::NRM_DEPTH];
	logic [3*vcd_pkg::WORD_W-1:0] pos_rd_q, nrm_rd_q;
	logic [2*vcd_pkg::WORD_W-1:0] tex_rd_q;

	// write appended entries, read one vertex's entries
	always_ff @(posedge clk) begin
		if (wr.we_pos) pos_mem[wr.pos_addr] <= {wr.word_x, wr.word_y, wr.word_z};
		if (wr.we_tex) tex_mem[wr.tex_addr] <= {wr.word_x, wr.word_y};
		if (wr.we_nrm) nrm_mem[wr.nrm_addr] <= {wr.word_x, wr.word_y, wr.word_z};
		if (rd.en) begin
			pos_rd_q <= pos_mem[rd.pos_addr];
			tex_rd_q <= tex_mem[rd.tex_addr];
			nrm_rd_q <= nrm_mem[rd.nrm_addr];
		end
	end

	assign data = {pos_rd_q, tex_rd_q, nrm_rd_q};

endmodule

// ----- sv/vcd_back.sv -----
module vcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  vcd_pkg::corner_t    q_data,
	output logic                pop,
	output logic                clearing,
	output vcd_pkg::attr_rd_t   attr_rd,
	input  vcd_pkg::attr_data_t attr_data,
	output logic                done,
	output vcd_pkg::result_t    result
);

	vcd_pkg::slot_t table_mem [vcd_pkg::DEDUP_DEPTH];
	vcd_pkg::slot_t rd_q, wdata;
	vcd_pkg::back_state_t state_q, state_d;
	vcd_pkg::corner_t entry_q;
	vcd_pkg::result_t res_q, res_d;
	logic [vcd_pkg::DEDUP_AW-1:0] addr_q, clr_q, vidx_q, waddr, hash, addr_inc;
	logic [vcd_pkg::DEDUP_AW:0]   probe_q;
	logic [vcd_pkg::DEDUP_CW-1:0] nv_q;
	logic [31:0] hash_raw;
	logic we, emit, hit, last_probe, last_clr, table_full;

	// fold the key into a table address, kept below the depth
	always_comb begin
		hash_raw = {21'b0, q_data.pos} ^ ({21'b0, q_data.tex} << 5) ^ ({21'b0, q_data.nrm} << 10);
		hash     = vcd_pkg::DEDUP_AW'(hash_raw);
		if (32'(hash) >= vcd_pkg::DEDUP_DEPTH)
			hash = vcd_pkg::DEDUP_AW'(32'(hash) - vcd_pkg::DEDUP_DEPTH);
		addr_inc = (32'(addr_q) == vcd_pkg::DEDUP_DEPTH - 1) ? '0 : addr_q + 1'b1;
	end

	assign hit        = rd_q.valid && (rd_q.key == {entry_q.pos, entry_q.tex, entry_q.nrm});
	assign last_probe = 32'(probe_q) == vcd_pkg::DEDUP_DEPTH - 1;
	assign last_clr   = 32'(clr_q) == vcd_pkg::DEDUP_DEPTH - 1;
	assign table_full = 32'(nv_q) >= vcd_pkg::DEDUP_DEPTH;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vcd_pkg::S_CLEAR: if (last_clr) state_d = vcd_pkg::S_IDLE;
			vcd_pkg::S_IDLE:  if (!q_empty && !q_data.bad) state_d = vcd_pkg::S_READ;
			vcd_pkg::S_READ:  state_d = vcd_pkg::S_CHECK;
			vcd_pkg::S_CHECK: begin
				if (hit) state_d = vcd_pkg::S_IDLE;
				else if (!rd_q.valid) state_d = table_full ? vcd_pkg::S_IDLE : vcd_pkg::S_ATTR;
				else if (last_probe) state_d = vcd_pkg::S_IDLE;
				else state_d = vcd_pkg::S_READ;
			end
			vcd_pkg::S_ATTR:  state_d = vcd_pkg::S_IDLE;
			default:          state_d = vcd_pkg::S_IDLE;
		endcase
	end

	// outputs of each state
	always_comb begin
		pop        = 1'b0;
		we         = 1'b0;
		waddr      = addr_q;
		wdata      = '0;
		emit       = 1'b0;
		res_d      = '0;
		clearing   = (state_q == vcd_pkg::S_CLEAR);
		attr_rd.en       = 1'b0;
		attr_rd.pos_addr = vcd_pkg::POS_AW'(entry_q.pos - 1'b1);
		attr_rd.tex_addr = vcd_pkg::TEX_AW'(entry_q.tex - 1'b1);
		attr_rd.nrm_addr = vcd_pkg::NRM_AW'(entry_q.nrm - 1'b1);
		unique case (state_q)
			vcd_pkg::S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			vcd_pkg::S_IDLE: begin
				pop = !q_empty;
				if (!q_empty && q_data.bad) begin
					emit         = 1'b1;
					res_d.status = vcd_pkg::ST_BAD;
				end
			end
			vcd_pkg::S_READ: ;
			vcd_pkg::S_CHECK: begin
				if (hit) begin
					emit            = 1'b1;
					res_d.out_index = vcd_pkg::OUT_W'(rd_q.vidx);
				end else if (!rd_q.valid) begin
					if (table_full) begin
						emit         = 1'b1;
						res_d.status = vcd_pkg::ST_FULL;
					end else begin
						we         = 1'b1;
						wdata      = {1'b1, entry_q.pos, entry_q.tex, entry_q.nrm,
						              nv_q[vcd_pkg::DEDUP_AW-1:0]};
						attr_rd.en = 1'b1;
					end
				end else if (last_probe) begin
					emit         = 1'b1;
					res_d.status = vcd_pkg::ST_FULL;
				end
			end
			vcd_pkg::S_ATTR: begin
				emit            = 1'b1;
				res_d.out_index = vcd_pkg::OUT_W'(vidx_q);
				res_d.is_new    = 1'b1;
				res_d.pos_x     = attr_data.pos_x;
				res_d.pos_y     = attr_data.pos_y;
				res_d.pos_z     = attr_data.pos_z;
				res_d.tex_u     = attr_data.tex_u;
				res_d.tex_v     = attr_data.tex_v;
				res_d.nrm_x     = attr_data.nrm_x;
				res_d.nrm_y     = attr_data.nrm_y;
				res_d.nrm_z     = attr_data.nrm_z;
			end
			default: ;
		endcase
	end

	// key table: one write port, registered read at the probe address
	always_ff @(posedge clk) begin
		if (we) table_mem[waddr] <= wdata;
		rd_q <= table_mem[addr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == vcd_pkg::S_IDLE) entry_q <= q_data;
		if (state_q == vcd_pkg::S_CHECK) vidx_q <= nv_q[vcd_pkg::DEDUP_AW-1:0];
		if (emit) res_q <= res_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vcd_pkg::S_CLEAR;
			clr_q   <= '0;
			addr_q  <= '0;
			probe_q <= '0;
			nv_q    <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit;
			if (state_q == vcd_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == vcd_pkg::S_IDLE) begin
				addr_q  <= hash;
				probe_q <= '0;
			end
			if (state_q == vcd_pkg::S_CHECK && rd_q.valid && !hit) begin
				addr_q  <= addr_inc;
				probe_q <= probe_q + 1'b1;
			end
			if (we && state_q == vcd_pkg::S_CHECK) nv_q <= nv_q + 1'b1;
		end
	end

	assign result = res_q;

	// never insert past the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(nv_q) <= vcd_pkg::DEDUP_DEPTH)
		else $error("vertex count past table depth");

	// a new vertex always reports ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_new |-> result.status == vcd_pkg::ST_OK)
		else $error("new vertex with error status");

	// no item is taken from the queue and no result is given while clearing
	assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop && !done)
		else $error("activity during table clear");

	// an insert is followed by an attribute result
	assert property (@(posedge clk) disable iff (!arst_n)
		attr_rd.en |=> state_q == vcd_pkg::S_ATTR)
		else $error("insert not followed by attribute fetch");

endmodule

// ----- sv/vertex_corner_dedup_indexer_core.sv -----
// Vertex corner dedup indexer. Assert start with an item while busy is low; loads
// (position, texcoord, normal) append to their stores while these have room and
// give no result. Each face corner gives one result on the cycle done is high; it
// cannot be stalled, so the receiver must take it then. Corners queue four deep
// and busy rises while the queue is full. The back end takes one corner at a
// time: a bad corner is reported from idle, a known triple needs a read and a
// check of the key table, each extra probe on a collision adds another read and
// check, and a new vertex adds one attribute store read; the key table has a
// single read port. A new triple that arrives with the table full probes every
// slot and is reported as full. After reset busy stays high while the key table
// is cleared.
module vertex_corner_dedup_indexer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vcd_pkg::item_t   item,
	output logic             done,
	output vcd_pkg::result_t result
);

	logic accept, push, pop, q_full, q_empty, clearing;
	vcd_pkg::corner_t    corner, q_data;
	vcd_pkg::attr_wr_t   attr_wr;
	vcd_pkg::attr_rd_t   attr_rd;
	vcd_pkg::attr_data_t attr_data;

	assign busy   = q_full || clearing;
	assign accept = start && !busy;

	vcd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.push    (push),
		.corner  (corner),
		.attr_wr (attr_wr)
	);

	vcd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (corner),
		.pop    (pop),
		.rdata  (q_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	vcd_attr u_attr (
		.clk  (clk),
		.wr   (attr_wr),
		.rd   (attr_rd),
		.data (attr_data)
	);

	vcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.pop       (pop),
		.clearing  (clearing),
		.attr_rd   (attr_rd),
		.attr_data (attr_data),
		.done      (done),
		.result    (result)
	);

endmodule
